// ----- hdl/stream_find_replace_assert.svh -----
// ----------------------------------------------------------------------------
// Stream find-and-replace assertion macros
// Shared concurrent assertion forms used by the find-and-replace RTL.
// ----------------------------------------------------------------------------
`ifndef STREAM_FIND_REPLACE_ASSERT_SVH
`define STREAM_FIND_REPLACE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- hdl/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// Stream find-and-replace package
// Register map, byte constants, shared structs and the byte picking helper.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int unsigned ADDR_W    = 6;
    localparam int unsigned DATA_W    = 64;
    localparam int unsigned LEN_W     = 5;
    localparam int unsigned REG_BYTES = 16;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    typedef enum logic [2:0] {
        REG_PAT_LO  = 3'd0,
        REG_PAT_HI  = 3'd1,
        REG_PAT_LEN = 3'd2,
        REG_REP_LO  = 3'd3,
        REG_REP_HI  = 3'd4,
        REG_REP_LEN = 3'd5
    } t_reg_idx;

    // Tail of a burst that the window control hands to the emitter.
    typedef struct packed {
        logic nl;
        logic eoi;
    } t_burst_ctl;

    // Emitter status seen by the input side.
    typedef struct packed {
        logic empty;
        logic last_go;
    } t_emit_stat;

    // Byte idx of a 16-byte register pair; bytes beyond the pair read as zero.
    function automatic logic [7:0] pick_byte(input logic [127:0] bytes,
                                             input int unsigned idx);
        logic [7:0] b;
        b = 8'h00;
        if (idx < REG_BYTES) begin
            b = bytes[idx*8 +: 8];
        end
        return b;
    endfunction

endpackage

// ----- hdl/stream_find_replace.sv -----
// ----------------------------------------------------------------------------
// Stream find-and-replace
// Replaces every non-overlapping pattern occurrence in a byte stream.
// ----------------------------------------------------------------------------
// The block takes one text byte per item and rewrites the stream so that every
// non-overlapping occurrence of the configured pattern becomes the configured
// replacement, leftmost match first; a newline ends a line and flushes the
// window, and an item marked end of input flushes the window and closes the
// stream with a newline. An item that causes at most one output byte is taken
// every cycle while the output is not stalled, and its byte passes through the
// burst emitter into the output register. An item that causes n output bytes
// (a replacement, a flush or a closing newline, up to PATTERN_MAX + 1 or
// REPLACE_MAX + 1 bytes) holds the emitter and stalls the input until its last
// byte is handed over; the emitter puts out exactly one byte a cycle while the
// output is not stalled. The window is a row of PATTERN_MAX cells that each
// hold one pending byte, compare it with their pattern byte and shift left
// when the oldest byte leaves. The user writes configuration over the APB port
// at 8-byte steps and only while the block is idle; the block does not enforce
// it. A write to the pattern length discards any pending window bytes.
// ----------------------------------------------------------------------------
`include "stream_find_replace_assert.svh"

module stream_find_replace
    import sfr_pkg::*;
#(
    parameter int unsigned PATTERN_MAX = 16,
    parameter int unsigned REPLACE_MAX = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_in_byte,
    input  logic              i_end_of_input,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_out_byte,
    output logic              o_last_of_run,
    output logic              o_stream_done
);

    localparam int unsigned IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int unsigned CNT_W = $clog2(PATTERN_MAX + 1);
    localparam int unsigned RC_W  = $clog2(REPLACE_MAX + 1);

    // Configuration registers.
    logic [DATA_W-1:0] r_pat_lo, r_pat_hi, r_rep_lo, r_rep_hi;
    logic [LEN_W-1:0]  r_pat_len, r_rep_len;

    // Window fill: the number of pending bytes, always below the pattern length.
    logic [IDX_W-1:0]  r_fill, n_fill;

    logic              w_cfg_wr;
    t_reg_idx          w_reg_idx;
    logic [LEN_W-1:0]  w_plen_raw_m1;
    logic [IDX_W-1:0]  w_plen_m1;
    logic [RC_W-1:0]   w_rlen;

    logic              w_accept;
    logic              w_is_nl;
    logic              w_full;
    logic              w_match;
    logic              w_shift;
    logic [CNT_W-1:0]  w_fill_p1;
    logic [CNT_W-1:0]  w_win_cnt;
    logic [RC_W-1:0]   w_rep_len;
    t_burst_ctl        w_ctl;
    t_emit_stat        w_stat;

    logic [7:0]             w_view [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] w_ok;

    // ------------------------------------------------------------------
    // Configuration port. Writes complete in the access phase; reads are
    // answered combinationally from the selected register.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = t_reg_idx'(paddr[ADDR_W-1:3]);

    always_comb begin
        case (w_reg_idx)
            REG_PAT_LO:  prdata = r_pat_lo;
            REG_PAT_HI:  prdata = r_pat_hi;
            REG_PAT_LEN: prdata = DATA_W'(r_pat_len);
            REG_REP_LO:  prdata = r_rep_lo;
            REG_REP_HI:  prdata = r_rep_hi;
            REG_REP_LEN: prdata = DATA_W'(r_rep_len);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_pat_len <= LEN_W'(1);
            r_rep_lo  <= '0;
            r_rep_hi  <= '0;
            r_rep_len <= '0;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_PAT_LO:  r_pat_lo  <= pwdata;
                REG_PAT_HI:  r_pat_hi  <= pwdata;
                REG_PAT_LEN: r_pat_len <= pwdata[LEN_W-1:0];
                REG_REP_LO:  r_rep_lo  <= pwdata;
                REG_REP_HI:  r_rep_hi  <= pwdata;
                REG_REP_LEN: r_rep_len <= pwdata[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Effective lengths. A zero pattern length behaves as one, and both
    // lengths are clamped to the depth that the hardware provides.
    // ------------------------------------------------------------------
    assign w_plen_raw_m1 = (r_pat_len == '0) ? '0 : r_pat_len - LEN_W'(1);

    always_comb begin
        if (32'(w_plen_raw_m1) > 32'(PATTERN_MAX - 1)) begin
            w_plen_m1 = IDX_W'(PATTERN_MAX - 1);
        end else begin
            w_plen_m1 = IDX_W'(w_plen_raw_m1);
        end
        if (32'(r_rep_len) > 32'(REPLACE_MAX)) begin
            w_rlen = RC_W'(REPLACE_MAX);
        end else begin
            w_rlen = RC_W'(r_rep_len);
        end
    end

    // ------------------------------------------------------------------
    // Handshake. A new item is taken when the emitter is empty or is
    // handing over the last byte of its current burst in this cycle.
    // ------------------------------------------------------------------
    assign o_in_stall = !(w_stat.empty || w_stat.last_go);
    assign w_accept   = i_in_valid && !o_in_stall;

    // ------------------------------------------------------------------
    // Window row. Every cell sees the incoming byte; the cell at the fill
    // position takes it. When the window is full and does not match, all
    // cells move one place towards the oldest end.
    // ------------------------------------------------------------------
    assign w_is_nl = (i_in_byte == NEWLINE_BYTE);
    assign w_full  = (r_fill == w_plen_m1);
    assign w_match = !w_is_nl && w_full && (&w_ok);
    assign w_shift = w_full && !w_match;

    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
        logic [7:0] w_next_view;

        if (i == PATTERN_MAX - 1) begin : g_end
            assign w_next_view = i_in_byte;
        end else begin : g_mid
            assign w_next_view = w_view[i+1];
        end

        sfr_cell u_cell (
            .i_clk       (i_clk),
            .i_load      (w_accept),
            .i_shift     (w_shift),
            .i_sel       (r_fill == IDX_W'(i)),
            .i_byte      (i_in_byte),
            .i_next_view (w_next_view),
            .i_pat       (pick_byte({r_pat_hi, r_pat_lo}, i)),
            .i_in_use    (32'(i) <= 32'(w_plen_m1)),
            .o_view      (w_view[i]),
            .o_ok        (w_ok[i])
        );
    end

    // ------------------------------------------------------------------
    // Burst for the emitter. A newline flushes the pending bytes and then
    // passes itself on. Otherwise a match gives the replacement, a full
    // window without a match gives its oldest byte, and end of input gives
    // every byte still held. End of input also closes with a newline.
    // ------------------------------------------------------------------
    assign w_fill_p1 = CNT_W'(r_fill) + CNT_W'(1);

    always_comb begin
        if (w_is_nl) begin
            w_win_cnt = CNT_W'(r_fill);
        end else if (i_end_of_input) begin
            w_win_cnt = w_match ? '0 : w_fill_p1;
        end else begin
            w_win_cnt = w_shift ? CNT_W'(1) : '0;
        end
    end

    assign w_rep_len = w_match ? w_rlen : '0;
    assign w_ctl.nl  = w_is_nl || i_end_of_input;
    assign w_ctl.eoi = i_end_of_input;

    always_comb begin
        n_fill = r_fill;
        if (w_cfg_wr && (w_reg_idx == REG_PAT_LEN)) begin
            n_fill = '0;
        end else if (w_accept) begin
            if (w_is_nl || i_end_of_input || w_match) begin
                n_fill = '0;
            end else if (!w_full) begin
                n_fill = IDX_W'(w_fill_p1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    sfr_emit #(
        .PATTERN_MAX (PATTERN_MAX),
        .REPLACE_MAX (REPLACE_MAX)
    ) u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_accept),
        .i_ctl         (w_ctl),
        .i_rep_len     (w_rep_len),
        .i_win_cnt     (w_win_cnt),
        .i_win_bytes   (w_view),
        .i_rep_bytes   ({r_rep_hi, r_rep_lo}),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_stream_done (o_stream_done),
        .o_stat        (w_stat)
    );

    // ------------------------------------------------------------------
    // Checks on the window control.
    // ------------------------------------------------------------------
    `SFR_ASSERT_IMP(a_fill_below_len, i_clk, i_rst_n, 1'b1, r_fill <= w_plen_m1)
    `SFR_ASSERT_IMP(a_match_needs_full, i_clk, i_rst_n, w_match, w_full && !w_is_nl)
    `SFR_ASSERT_IMP(a_accept_frees_emit, i_clk, i_rst_n, w_accept,
                    w_stat.empty || w_stat.last_go)
    `SFR_ASSERT_NXT(a_line_end_clears, i_clk, i_rst_n, w_accept && w_is_nl, r_fill == '0)

endmodule

// ----- hdl/sfr_cell.sv -----
// ----------------------------------------------------------------------------
// Stream find-and-replace window cell
// Holds one window byte, compares it with its pattern byte, shifts left.
// ----------------------------------------------------------------------------
module sfr_cell (
    input  logic       i_clk,
    input  logic       i_load,
    input  logic       i_shift,
    input  logic       i_sel,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_next_view,
    input  logic [7:0] i_pat,
    input  logic       i_in_use,
    output logic [7:0] o_view,
    output logic       o_ok
);

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    // The incoming byte lands in the cell that sits at the current fill.
    assign o_view = i_sel ? i_byte : r_byte;
    assign o_ok   = !i_in_use || (o_view == i_pat);

    always_comb begin
        n_byte = r_byte;
        if (i_load) begin
            n_byte = i_shift ? i_next_view : o_view;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

endmodule

// ----- hdl/sfr_emit.sv -----
// ----------------------------------------------------------------------------
// Stream find-and-replace burst emitter
// Plays replacement bytes, window bytes and a newline into the output register.
// ----------------------------------------------------------------------------
module sfr_emit
    import sfr_pkg::*;
#(
    parameter int unsigned PATTERN_MAX = 16,
    parameter int unsigned REPLACE_MAX = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_load,
    input  t_burst_ctl                                  i_ctl,
    input  logic [$clog2(REPLACE_MAX+1)-1:0]            i_rep_len,
    input  logic [$clog2(PATTERN_MAX+1)-1:0]            i_win_cnt,
    input  logic [7:0]                                  i_win_bytes [PATTERN_MAX],
    input  logic [127:0]                                i_rep_bytes,
    input  logic                                        i_out_stall,
    output logic                                        o_out_valid,
    output logic [7:0]                                  o_out_byte,
    output logic                                        o_last_of_run,
    output logic                                        o_stream_done,
    output t_emit_stat                                  o_stat
);

    localparam int unsigned RC_W  = $clog2(REPLACE_MAX + 1);
    localparam int unsigned RI_W  = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1;
    localparam int unsigned CNT_W = $clog2(PATTERN_MAX + 1);

    logic [RC_W-1:0]  r_rep_left, n_rep_left;
    logic [RI_W-1:0]  r_rep_idx, n_rep_idx;
    logic [7:0]       r_win [PATTERN_MAX];
    logic [7:0]       n_win [PATTERN_MAX];
    logic [CNT_W-1:0] r_win_cnt, n_win_cnt;
    logic             r_nl, n_nl;
    logic             r_eoi, n_eoi;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_byte, n_out_byte;
    logic             r_out_last, n_out_last;
    logic             r_out_done, n_out_done;

    logic             w_has_rep;
    logic             w_has_win;
    logic             w_empty;
    logic             w_advance;
    logic [7:0]       w_cur_byte;
    logic             w_cur_last;

    assign w_has_rep = (r_rep_left != '0);
    assign w_has_win = (r_win_cnt != '0);
    assign w_empty   = !w_has_rep && !w_has_win && !r_nl;
    assign w_advance = !w_empty && (!r_out_valid || !i_out_stall);

    // Replacement first, then window bytes, then the newline.
    always_comb begin
        if (w_has_rep) begin
            w_cur_byte = pick_byte(i_rep_bytes, 32'(r_rep_idx));
            w_cur_last = (r_rep_left == RC_W'(1)) && !w_has_win && !r_nl;
        end else if (w_has_win) begin
            w_cur_byte = r_win[0];
            w_cur_last = (r_win_cnt == CNT_W'(1)) && !r_nl;
        end else begin
            w_cur_byte = NEWLINE_BYTE;
            w_cur_last = 1'b1;
        end
    end

    assign o_stat.empty   = w_empty;
    assign o_stat.last_go = w_advance && w_cur_last;

    always_comb begin
        n_rep_left = r_rep_left;
        n_rep_idx  = r_rep_idx;
        n_win      = r_win;
        n_win_cnt  = r_win_cnt;
        n_nl       = r_nl;
        n_eoi      = r_eoi;
        if (i_load) begin
            n_rep_left = i_rep_len;
            n_rep_idx  = '0;
            n_win      = i_win_bytes;
            n_win_cnt  = i_win_cnt;
            n_nl       = i_ctl.nl;
            n_eoi      = i_ctl.eoi;
        end else if (w_advance) begin
            if (w_has_rep) begin
                n_rep_left = r_rep_left - RC_W'(1);
                n_rep_idx  = r_rep_idx + RI_W'(1);
            end else if (w_has_win) begin
                for (int i = 0; i < PATTERN_MAX - 1; i++) begin
                    n_win[i] = r_win[i+1];
                end
                n_win_cnt = r_win_cnt - CNT_W'(1);
            end else begin
                n_nl = 1'b0;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_done  = r_out_done;
        if (w_advance) begin
            n_out_valid = 1'b1;
            n_out_byte  = w_cur_byte;
            n_out_last  = w_cur_last;
            n_out_done  = w_cur_last && r_eoi;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep_left  <= '0;
            r_win_cnt   <= '0;
            r_nl        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rep_left  <= n_rep_left;
            r_win_cnt   <= n_win_cnt;
            r_nl        <= n_nl;
            r_out_valid <= n_out_valid;
        end
        r_rep_idx  <= n_rep_idx;
        r_win      <= n_win;
        r_eoi      <= n_eoi;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_done <= n_out_done;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;
    assign o_stream_done = r_out_done;

endmodule
